@@ sv/dpid_pkg.sv @@
package dpid_pkg;

  // Field widths of the item payloads and configuration registers
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned FIELD_W  = 12;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned TARGET_W = 12;

  // Default datapath sizing
  localparam int unsigned PULSE_BITS_DEF = 12;
  localparam int unsigned SUM_BITS_DEF   = 24;

  // APB register file
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 3;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_GAIN_P_X = 3'd0;
  localparam reg_idx_t REG_GAIN_I_X = 3'd1;
  localparam reg_idx_t REG_GAIN_D_X = 3'd2;
  localparam reg_idx_t REG_GAIN_P_Y = 3'd3;
  localparam reg_idx_t REG_GAIN_I_Y = 3'd4;
  localparam reg_idx_t REG_GAIN_D_Y = 3'd5;
  localparam reg_idx_t REG_TARGET_X = 3'd6;
  localparam reg_idx_t REG_TARGET_Y = 3'd7;

  // Tick commands; both idle codes give no result
  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_IDLE     = 2'd0;
  localparam cmd_t CMD_RUN_X    = 2'd1;
  localparam cmd_t CMD_RUN_Y    = 2'd2;
  localparam cmd_t CMD_IDLE_ALT = 2'd3;

endpackage

@@ sv/dpid_if.sv @@
// Tick channel: command plus measured and current pulse values
interface dpid_in_if;
  import dpid_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [FIELD_W-1:0] measured_pulses;
  logic [FIELD_W-1:0] base_pulses;

  modport source (
    output valid, command, measured_pulses, base_pulses,
    input  ready
  );

  modport sink (
    input  valid, command, measured_pulses, base_pulses,
    output ready
  );
endinterface

// Drive channel: new pulse value for one servo
interface dpid_out_if;
  import dpid_pkg::*;

  logic               valid;
  logic               ready;
  logic               axis;
  logic [FIELD_W-1:0] drive_pulses;
  logic               clipped;

  modport source (
    output valid, axis, drive_pulses, clipped,
    input  ready
  );

  modport sink (
    input  valid, axis, drive_pulses, clipped,
    output ready
  );
endinterface

@@ sv/dual_axis_positional_pid.sv @@
// Dual-axis positional PID controller.
//
// in_ch carries one control tick per item: command 1 runs the X loop,
// command 2 runs the Y loop, commands 0 and 3 are dropped with no result
// and no state change. out_ch returns one item per run tick: the axis,
// the new servo pulse value and a flag set when that value hit 0 or the
// top of the pulse range.
// Gains (signed Q8.8) and setpoints are written over the APB port, by the
// user only while the block is idle; the block does not enforce this.
// Reads return the stored values. A taken tick sits in the input register,
// the loop math runs combinationally from it, and the output register
// captures the result for out_ch. One tick per cycle is sustained while
// out_ch is ready; the multiply-add and its error state update set that rate.
// A stalled receiver holds the output register; one more tick still
// enters the input register, after which in_ch.ready drops until the
// output drains. Loop state advances only when a tick moves to the output.
// Reset clears the registers, the error sums, the prior errors and both
// pipeline stages.
module dual_axis_positional_pid #(
  parameter int unsigned PULSE_BITS = dpid_pkg::PULSE_BITS_DEF,
  parameter int unsigned SUM_BITS   = dpid_pkg::SUM_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  dpid_in_if.sink                         in_ch,
  dpid_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dpid_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [dpid_pkg::APB_DATA_W-1:0] pwdata,
  output logic [dpid_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  import dpid_pkg::*;

  // Datapath widths
  localparam int unsigned ERR_W  = FIELD_W + 1;
  localparam int unsigned DIFF_W = ERR_W + 1;
  localparam int unsigned ACC_W  = SUM_BITS + GAIN_W + 2;
  localparam int unsigned PID_W  = ACC_W - 8;
  localparam int unsigned D_W    = PID_W + 1;
  localparam int unsigned MASK_BITS = (PULSE_BITS < FIELD_W) ? PULSE_BITS : FIELD_W;
  localparam logic [FIELD_W-1:0] FIELD_MASK =
    FIELD_W'((64'd1 << MASK_BITS) - 64'd1);
  localparam logic signed [D_W-1:0] DRIVE_TOP =
    D_W'((64'sd1 <<< PULSE_BITS) - 64'sd1);
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(128);

  // Configuration registers
  logic [GAIN_W-1:0]   gain_p_x_q, gain_i_x_q, gain_d_x_q;
  logic [GAIN_W-1:0]   gain_p_y_q, gain_i_y_q, gain_d_y_q;
  logic [TARGET_W-1:0] target_x_q, target_y_q;
  reg_idx_t            reg_idx;
  logic                cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_x_q <= '0;
      gain_i_x_q <= '0;
      gain_d_x_q <= '0;
      gain_p_y_q <= '0;
      gain_i_y_q <= '0;
      gain_d_y_q <= '0;
      target_x_q <= '0;
      target_y_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_GAIN_P_X: gain_p_x_q <= pwdata[GAIN_W-1:0];
        REG_GAIN_I_X: gain_i_x_q <= pwdata[GAIN_W-1:0];
        REG_GAIN_D_X: gain_d_x_q <= pwdata[GAIN_W-1:0];
        REG_GAIN_P_Y: gain_p_y_q <= pwdata[GAIN_W-1:0];
        REG_GAIN_I_Y: gain_i_y_q <= pwdata[GAIN_W-1:0];
        REG_GAIN_D_Y: gain_d_y_q <= pwdata[GAIN_W-1:0];
        REG_TARGET_X: target_x_q <= pwdata[TARGET_W-1:0];
        REG_TARGET_Y: target_y_q <= pwdata[TARGET_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      REG_GAIN_P_X: prdata = APB_DATA_W'(gain_p_x_q);
      REG_GAIN_I_X: prdata = APB_DATA_W'(gain_i_x_q);
      REG_GAIN_D_X: prdata = APB_DATA_W'(gain_d_x_q);
      REG_GAIN_P_Y: prdata = APB_DATA_W'(gain_p_y_q);
      REG_GAIN_I_Y: prdata = APB_DATA_W'(gain_i_y_q);
      REG_GAIN_D_Y: prdata = APB_DATA_W'(gain_d_y_q);
      REG_TARGET_X: prdata = APB_DATA_W'(target_x_q);
      REG_TARGET_Y: prdata = APB_DATA_W'(target_y_q);
      default:      prdata = '0;
    endcase
  end

  // Handshake: input register and output register
  logic               in_valid_q, in_valid_d;
  logic               in_is_y_q;
  logic [FIELD_W-1:0] meas_q, base_q;
  logic               out_valid_q, out_valid_d;
  logic               advance;
  logic               in_fire;
  logic               move;
  logic               is_run;

  assign advance      = !out_valid_q || out_ch.ready;
  assign in_ch.ready  = !in_valid_q || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign move         = advance && in_valid_q;
  assign is_run       = (in_ch.command == CMD_RUN_X) || (in_ch.command == CMD_RUN_Y);
  assign out_ch.valid = out_valid_q;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = is_run;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = advance ? in_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_is_y_q <= (in_ch.command == CMD_RUN_Y);
      meas_q    <= in_ch.measured_pulses & FIELD_MASK;
      base_q    <= in_ch.base_pulses & FIELD_MASK;
    end
  end

  // Loop state
  logic signed [SUM_BITS-1:0] sum_x_q, sum_y_q, sum_d;
  logic signed [ERR_W-1:0]    prior_x_q, prior_y_q;

  // Select the active loop
  logic signed [GAIN_W-1:0]   kp, ki, kd;
  logic [FIELD_W-1:0]         target;
  logic signed [SUM_BITS-1:0] sum_sel;
  logic signed [ERR_W-1:0]    prior_sel;

  always_comb begin
    if (in_is_y_q) begin
      kp        = gain_p_y_q;
      ki        = gain_i_y_q;
      kd        = gain_d_y_q;
      target    = FIELD_W'(target_y_q) & FIELD_MASK;
      sum_sel   = sum_y_q;
      prior_sel = prior_y_q;
    end else begin
      kp        = gain_p_x_q;
      ki        = gain_i_x_q;
      kd        = gain_d_x_q;
      target    = FIELD_W'(target_x_q) & FIELD_MASK;
      sum_sel   = sum_x_q;
      prior_sel = prior_x_q;
    end
  end

  // Error, saturating sum and difference
  logic signed [ERR_W-1:0]    err;
  logic signed [SUM_BITS:0]   sum_wide;
  logic signed [DIFF_W-1:0]   diff;

  always_comb begin
    err      = $signed({1'b0, meas_q}) - $signed({1'b0, target});
    sum_wide = $signed({sum_sel[SUM_BITS-1], sum_sel}) + (SUM_BITS+1)'(err);
    if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
      // overflow: clamp toward the sign of the wide sum
      sum_d = {sum_wide[SUM_BITS], {(SUM_BITS-1){~sum_wide[SUM_BITS]}}};
    end else begin
      sum_d = sum_wide[SUM_BITS-1:0];
    end
    diff = DIFF_W'(err) - DIFF_W'(prior_sel);
  end

  // PID products and rounded Q8.8 sum
  logic signed [GAIN_W+ERR_W-1:0]    p_prod;
  logic signed [GAIN_W+SUM_BITS-1:0] i_prod;
  logic signed [GAIN_W+DIFF_W-1:0]   d_prod;
  logic signed [ACC_W-1:0]           acc;
  logic signed [PID_W-1:0]           pid;

  always_comb begin
    p_prod = kp * err;
    i_prod = ki * sum_d;
    d_prod = kd * diff;
    acc    = ACC_W'(p_prod) + ACC_W'(i_prod) + ACC_W'(d_prod) + ROUND_HALF;
    pid    = acc[ACC_W-1:8];
  end

  // Drive and saturation to the pulse range
  logic signed [D_W-1:0] drive_raw;
  logic signed [D_W-1:0] drive_sat;
  logic                  clip;

  always_comb begin
    if (in_is_y_q) begin
      drive_raw = $signed(D_W'(base_q)) + D_W'(pid);
    end else begin
      drive_raw = $signed(D_W'(base_q)) - D_W'(pid);
    end
    clip      = 1'b0;
    drive_sat = drive_raw;
    if (drive_raw < 0) begin
      drive_sat = '0;
      clip      = 1'b1;
    end else if (drive_raw > DRIVE_TOP) begin
      drive_sat = DRIVE_TOP;
      clip      = 1'b1;
    end
  end

  // State update when the tick moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q   <= '0;
      sum_y_q   <= '0;
      prior_x_q <= '0;
      prior_y_q <= '0;
    end else if (move) begin
      if (in_is_y_q) begin
        sum_y_q   <= sum_d;
        prior_y_q <= err;
      end else begin
        sum_x_q   <= sum_d;
        prior_x_q <= err;
      end
    end
  end

  // Output register
  logic               axis_q;
  logic [FIELD_W-1:0] drive_q;
  logic               clip_q;

  always_ff @(posedge clk_i) begin
    if (move) begin
      axis_q  <= in_is_y_q;
      drive_q <= drive_sat[FIELD_W-1:0];
      clip_q  <= clip;
    end
  end

  assign out_ch.axis         = axis_q;
  assign out_ch.drive_pulses = drive_q;
  assign out_ch.clipped      = clip_q;

endmodule
